[design/mtm_pkg.sv]
// Shared types, codes and helpers for the MIDI trigger matcher.
// No dependencies; every other design file refers to this package by scoped names.
package mtm_pkg;

    // Number of prioritized bindings and the width of a slot index.
    localparam int SLOTS      = 6;
    localparam int SLOT_WIDTH = $clog2(SLOTS);

    // Event counters and the fixed width at which they are reported.
    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH = 16;

    // Depth of the queue between the matcher and the counter stage.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register file.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 26;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BINDING0 = 3'd1;

    // MIDI status decoding.
    localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
    localparam logic [7:0] STATUS_CHAN_MASK = 8'h0F;
    localparam logic [7:0] STATUS_PROGRAM   = 8'hC0;
    localparam logic [7:0] STATUS_CONTROL   = 8'hB0;
    localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
    localparam logic [6:0] PROGRAM_VALUE    = 7'd127;

    // Message kinds as stored in a binding.
    localparam logic [1:0] KIND_PROGRAM = 2'd0;
    localparam logic [1:0] KIND_CONTROL = 2'd1;
    localparam logic [1:0] KIND_NOTE_ON = 2'd2;

    // Action codes; go-to-numbered is the highest legal one.
    localparam logic [2:0] ACT_GOTO_NUMBERED = 3'd4;

    // Outcome codes.
    localparam logic [1:0] OUTCOME_NONE    = 2'd0;
    localparam logic [1:0] OUTCOME_FIRED   = 2'd1;
    localparam logic [1:0] OUTCOME_DROPPED = 2'd2;

    // One binding register, most significant field first (bits 25..0).
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [4:0] channel;
        logic [6:0] number;
        logic [6:0] threshold;
        logic [2:0] action;
        logic       also_switch;
    } t_binding;

    // Match result handed from the front to the counter stage.
    typedef struct packed {
        logic                  hit;
        logic                  busy;
        logic [2:0]            action;
        logic [6:0]            cue;
        logic                  also_switch;
        logic [SLOT_WIDTH-1:0] slot;
    } t_job;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [TOTAL_WIDTH-1:0] t_total;

    localparam t_count COUNT_MAX = '1;

    function automatic t_count sat_inc(input t_count c);
        return (c == COUNT_MAX) ? c : c + t_count'(1);
    endfunction

    // Low TOTAL_WIDTH bits of a counter, zero-extended if the counter is narrower.
    function automatic t_total count_to_total(input t_count c);
        logic [TOTAL_WIDTH+COUNT_WIDTH-1:0] wide;
        wide = {{TOTAL_WIDTH{1'b0}}, c};
        return wide[TOTAL_WIDTH-1:0];
    endfunction

endpackage

[design/midi_trigger_matcher.sv]
// An accepted message beat is written into the queue, then popped by the back into the
// result output register, where the result beat waits until it is taken.
// Throughput: one message per cycle sustained while the result side keeps ready high.
// The two-entry queue between matcher and counter stage absorbs a stalled result side.
// Reset (i_rst_n low, synchronous) clears enable, all bindings, both counters and
// every valid flag; no clearing pass is needed, so a message can enter right after reset.
module midi_trigger_matcher (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel: index 0 is enable, 1..6 are binding_0..binding_5.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mtm_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [mtm_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data,
    // Message channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [7:0]                            i_status_byte,
    input  logic [6:0]                            i_data_first,
    input  logic [6:0]                            i_data_second,
    input  logic                                  i_switch_busy,
    // Result channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_outcome,
    output logic [2:0]                            o_action_code,
    output logic [6:0]                            o_cue_number,
    output logic                                  o_switch_after,
    output logic [mtm_pkg::SLOT_WIDTH-1:0]        o_matched_slot,
    output logic [mtm_pkg::TOTAL_WIDTH-1:0]       o_fired_total,
    output logic [mtm_pkg::TOTAL_WIDTH-1:0]       o_dropped_total
);

    // Registers are plain flops, so a configuration beat is always taken at once.
    // Writes to indexes beyond the last binding are accepted and dropped.
    assign o_cfg_ready = 1'b1;

    logic          q_ready;
    logic          push;
    mtm_pkg::t_job front_job;
    logic          q_valid;
    logic          pop;
    mtm_pkg::t_job back_job;

    // The front classifies the status byte and compares the message with all six
    // bindings in parallel in the accept cycle. Only the first matching binding
    // survives the priority pick. A message beat is taken whenever the queue
    // has room, regardless of whether the result side is stalled.
    mtm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_status_byte (i_status_byte),
        .i_data_first  (i_data_first),
        .i_data_second (i_data_second),
        .i_switch_busy (i_switch_busy),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_job         (front_job)
    );

    // The queue holds match results, so the front and back stall independently.
    mtm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    // The back updates the saturating counters in queue order, which keeps the
    // reported totals consistent with the order of the message beats, and holds
    // the result beat in an output register until it is taken.
    mtm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (q_valid),
        .i_job           (back_job),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_outcome       (o_outcome),
        .o_action_code   (o_action_code),
        .o_cue_number    (o_cue_number),
        .o_switch_after  (o_switch_after),
        .o_matched_slot  (o_matched_slot),
        .o_fired_total   (o_fired_total),
        .o_dropped_total (o_dropped_total)
    );

endmodule

[design/mtm_front.sv]
// Front of the MIDI trigger matcher: configuration registers, message classification
// and the prioritized compare against all bindings. Depends on mtm_pkg.
module mtm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [mtm_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [mtm_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [7:0]                            i_status_byte,
    input  logic [6:0]                            i_data_first,
    input  logic [6:0]                            i_data_second,
    input  logic                                  i_switch_busy,
    input  logic                                  i_q_ready,
    output logic                                  o_push,
    output mtm_pkg::t_job                         o_job
);

    logic              r_enable;
    mtm_pkg::t_binding r_bind [mtm_pkg::SLOTS];

    logic       known;
    logic [1:0] kind;
    logic [6:0] value;
    logic [4:0] chan;
    logic [mtm_pkg::SLOTS-1:0] slot_hit;
    logic                      any_hit;
    logic [mtm_pkg::SLOT_WIDTH-1:0] sel;
    mtm_pkg::t_binding         pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            for (int s = 0; s < mtm_pkg::SLOTS; s++) begin
                r_bind[s] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mtm_pkg::REG_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end
            for (int s = 0; s < mtm_pkg::SLOTS; s++) begin
                if (i_cfg_index == mtm_pkg::REG_BINDING0 + mtm_pkg::CFG_INDEX_WIDTH'(s)) begin
                    r_bind[s] <= mtm_pkg::t_binding'(i_cfg_data);
                end
            end
        end
    end

    // Classify the status byte; program change always carries full value.
    always_comb begin
        known = 1'b1;
        kind  = mtm_pkg::KIND_PROGRAM;
        value = i_data_second;
        case (i_status_byte & mtm_pkg::STATUS_TYPE_MASK)
            mtm_pkg::STATUS_PROGRAM: begin
                kind  = mtm_pkg::KIND_PROGRAM;
                value = mtm_pkg::PROGRAM_VALUE;
            end
            mtm_pkg::STATUS_CONTROL: kind = mtm_pkg::KIND_CONTROL;
            mtm_pkg::STATUS_NOTE_ON: kind = mtm_pkg::KIND_NOTE_ON;
            default:                 known = 1'b0;
        endcase
        chan = {1'b0, i_status_byte[3:0] & mtm_pkg::STATUS_CHAN_MASK[3:0]} + 5'd1;
    end

    // One comparator per binding, then a priority pick toward slot zero.
    always_comb begin
        for (int s = 0; s < mtm_pkg::SLOTS; s++) begin
            slot_hit[s] = r_enable && known
                && r_bind[s].valid
                && (r_bind[s].action <= mtm_pkg::ACT_GOTO_NUMBERED)
                && (r_bind[s].kind == kind)
                && ((r_bind[s].channel == 5'd0) || (r_bind[s].channel == chan))
                && ((r_bind[s].action == mtm_pkg::ACT_GOTO_NUMBERED)
                    || (r_bind[s].number == i_data_first))
                && (value >= r_bind[s].threshold);
        end
        any_hit = |slot_hit;
        sel     = '0;
        for (int s = mtm_pkg::SLOTS - 1; s >= 0; s--) begin
            if (slot_hit[s]) begin
                sel = mtm_pkg::SLOT_WIDTH'(s);
            end
        end
        pick = r_bind[sel];
    end

    always_comb begin
        o_job.hit         = any_hit;
        o_job.busy        = i_switch_busy;
        o_job.action      = any_hit ? pick.action : 3'd0;
        o_job.cue         = any_hit ? i_data_first : 7'd0;
        o_job.also_switch = any_hit ? pick.also_switch : 1'b0;
        o_job.slot        = any_hit ? sel : '0;
    end

    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;

endmodule

[design/mtm_queue.sv]
// Short register queue that decouples the matcher from the counter stage.
// Depends on mtm_pkg for the entry type and depth.
module mtm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtm_pkg::t_job i_job,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output mtm_pkg::t_job o_job
);

    localparam int PTR_WIDTH = (mtm_pkg::QUEUE_DEPTH > 1) ? $clog2(mtm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(mtm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(mtm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(mtm_pkg::QUEUE_DEPTH);

    mtm_pkg::t_job          r_mem [mtm_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_WIDTH-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_WIDTH-1:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_WIDTH'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_WIDTH'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_WIDTH'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

[design/mtm_back.sv]
// Back of the MIDI trigger matcher: saturating fired and dropped counters and the
// registered result beat. Depends on mtm_pkg.
module mtm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  mtm_pkg::t_job                      i_job,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_outcome,
    output logic [2:0]                         o_action_code,
    output logic [6:0]                         o_cue_number,
    output logic                               o_switch_after,
    output logic [mtm_pkg::SLOT_WIDTH-1:0]     o_matched_slot,
    output logic [mtm_pkg::TOTAL_WIDTH-1:0]    o_fired_total,
    output logic [mtm_pkg::TOTAL_WIDTH-1:0]    o_dropped_total
);

    logic                 r_out_valid;
    mtm_pkg::t_count      r_fired,   n_fired;
    mtm_pkg::t_count      r_dropped, n_dropped;
    logic [1:0]           r_outcome, n_outcome;
    mtm_pkg::t_job        r_job;
    mtm_pkg::t_total      r_fired_total, r_dropped_total;

    assign o_pop = i_job_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_fired   = r_fired;
        n_dropped = r_dropped;
        n_outcome = mtm_pkg::OUTCOME_NONE;
        if (i_job.hit) begin
            if (i_job.busy) begin
                n_outcome = mtm_pkg::OUTCOME_DROPPED;
                n_dropped = mtm_pkg::sat_inc(r_dropped);
            end else begin
                n_outcome = mtm_pkg::OUTCOME_FIRED;
                n_fired   = mtm_pkg::sat_inc(r_fired);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fired     <= '0;
            r_dropped   <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_fired     <= n_fired;
                r_dropped   <= n_dropped;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_outcome       <= n_outcome;
            r_job           <= i_job;
            r_fired_total   <= mtm_pkg::count_to_total(n_fired);
            r_dropped_total <= mtm_pkg::count_to_total(n_dropped);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_outcome       = r_outcome;
    assign o_action_code   = r_job.action;
    assign o_cue_number    = r_job.cue;
    assign o_switch_after  = r_job.also_switch;
    assign o_matched_slot  = r_job.slot;
    assign o_fired_total   = r_fired_total;
    assign o_dropped_total = r_dropped_total;

    // Counters never go down outside reset.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fired >= $past(r_fired)) && (r_dropped >= $past(r_dropped)))
        else $error("event counter decreased");

    // Counters move only when a job is taken from the queue.
    a_count_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(o_pop) |-> $stable(r_fired) && $stable(r_dropped))
        else $error("counter changed without a job");

    // A single job steps at most one of the two counters.
    a_one_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !((r_fired != $past(r_fired)) && (r_dropped != $past(r_dropped))))
        else $error("both counters stepped for one job");

    // A result without a match carries no binding details.
    a_none_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_outcome == mtm_pkg::OUTCOME_NONE) |->
            (r_job.action == 3'd0) && (r_job.cue == 7'd0)
            && !r_job.also_switch && (r_job.slot == '0))
        else $error("unmatched result carries binding fields");

endmodule
